@@ rtl/core/sks_pkg.sv @@
// Package for the sorted table key search core.
// Holds the field widths, codes, controller state type and command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KEY_W      = 34;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 10;
    localparam int CFG_CNT_W  = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic MODE_SEQ = 1'b0;
    localparam logic MODE_BIN = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SEARCH_MODE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic write;
        logic load;
        logic probe;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic finish;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sks_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sks_regs.sv @@
// Configuration registers behind the APB-style port: entry count and search mode.
// Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sks_regs
    import sks_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CFG_CNT_W-1:0]  entry_count,
    output logic                       search_mode
);

    logic                 wr_en;
    logic                 reg_sel;
    logic [CFG_CNT_W-1:0] entry_count_reg;
    logic [CFG_CNT_W-1:0] entry_count_next;
    logic                 search_mode_reg;
    logic                 search_mode_next;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        entry_count_next = entry_count_reg;
        search_mode_next = search_mode_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENTRY_COUNT: entry_count_next = pwdata[CFG_CNT_W-1:0];
                REG_SEARCH_MODE: search_mode_next = pwdata[0];
                default:         entry_count_next = entry_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ENTRY_COUNT: prdata = CFG_DATA_W'(entry_count_reg);
            REG_SEARCH_MODE: prdata = CFG_DATA_W'(search_mode_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            search_mode_reg <= MODE_SEQ;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            search_mode_reg <= search_mode_next;
        end
    end

    assign entry_count = entry_count_reg;
    assign search_mode = search_mode_reg;

endmodule

`default_nettype wire

@@ rtl/core/sks_ctrl.sv @@
// Controller state machine: accepts requests and sequences the table probes.
// Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sks_ctrl
    import sks_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       func,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (func == FUNC_SEARCH) && !status.count_zero)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.write = start && (func == FUNC_WRITE);
                cmd.load  = start && (func == FUNC_SEARCH);
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                busy      = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sks_datapath.sv @@
// Datapath: key table RAM, search bounds, probe address and result registers.
// Depends on sks_pkg and sks_ram.
`timescale 1ns / 1ps
`default_nettype none

module sks_datapath
    import sks_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    input  wire logic [IDX_W-1:0]     entry_index,
    input  wire logic [KEY_W-1:0]     key_value,
    input  wire logic [CFG_CNT_W-1:0] entry_count,
    input  wire logic                 search_mode,
    output dp_status_t                status,
    output logic                      done,
    output logic                      found,
    output logic      [POS_W-1:0]     position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    logic [CNT_W-1:0]  count_clamp;
    logic [CNT_W-1:0]  init_addr;
    logic              wr_en;
    logic [KEY_W-1:0]  rdata;
    logic              key_eq;
    logic              key_gt;
    logic              key_lt;
    logic              finish;
    logic              emit;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  hi_next;
    logic [CNT_W-1:0]  addr_reg;
    logic [CNT_W-1:0]  addr_next;
    logic [CNT_W-1:0]  probe_next;
    logic [KEY_W-1:0]  key_reg;
    logic              mode_reg;
    logic              done_reg;
    logic              found_reg;
    logic [POS_W-1:0]  position_reg;

    assign count_clamp = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(entry_count);
    assign init_addr   = (search_mode == MODE_BIN)
                       ? CNT_W'((SUM_W'(count_clamp) - SUM_W'(1)) >> 1) : '0;

    assign wr_en = cmd.write && (32'(entry_index) < 32'(TABLE_DEPTH));

    sks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ADDR_W'(entry_index)),
        .wdata (key_value),
        .re    (cmd.load | cmd.probe),
        .raddr (ADDR_W'(addr_next)),
        .rdata (rdata)
    );

    assign key_eq = (key_reg == rdata);
    assign key_gt = (key_reg > rdata);
    assign key_lt = (key_reg < rdata);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (mode_reg == MODE_BIN)
        begin
            if (key_gt)
            begin
                lo_next = CNT_W'(SUM_W'(addr_reg) + SUM_W'(1));
            end
            if (key_lt)
            begin
                hi_next = addr_reg;
            end
            finish     = key_eq || (lo_next >= hi_next);
            probe_next = CNT_W'((SUM_W'(lo_next) + SUM_W'(hi_next) - SUM_W'(1)) >> 1);
        end
        else
        begin
            finish     = key_eq || ((SUM_W'(addr_reg) + SUM_W'(1)) == SUM_W'(hi_reg));
            probe_next = CNT_W'(SUM_W'(addr_reg) + SUM_W'(1));
        end
    end

    assign addr_next = cmd.load ? init_addr : probe_next;

    assign status.count_zero = (count_clamp == '0);
    assign status.finish     = finish;

    assign emit = (cmd.load && status.count_zero) || (cmd.probe && finish);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg   <= '0;
            hi_reg   <= count_clamp;
            addr_reg <= init_addr;
            key_reg  <= key_value;
            mode_reg <= search_mode;
        end
        else if (cmd.probe && !finish)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            addr_reg <= probe_next;
        end
        if (emit)
        begin
            found_reg    <= cmd.probe && key_eq;
            position_reg <= (cmd.probe && key_eq) ? POS_W'(addr_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_key_search_core.sv @@
// Top level of the sorted table key search core.
// Depends on sks_pkg, sks_regs, sks_ctrl and sks_datapath.
//
// Channel   Handshake               Payload
// request   start high, busy low    func, entry_index, key_value
// result    done high for one cycle found, position
// config    APB write, pready high  paddr, pwdata (prdata on reads)
//
// A search makes one table probe per cycle through the single RAM read port: up to
// floor(log2(count)) + 1 probes in binary mode, up to count in sequential mode. The result
// strobes in the cycle after the last probe, when the next request can already be taken;
// on an empty table the miss strobes in the cycle after the request. Reset clears the
// control state, the configuration registers and done but not the table or the other
// datapath registers, and the receiver cannot stall a result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_key_search_core
    import sks_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  func,
    input  wire logic [IDX_W-1:0]      entry_index,
    input  wire logic [KEY_W-1:0]      key_value,
    output logic                       busy,
    output logic                       done,
    output logic                       found,
    output logic      [POS_W-1:0]      position,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CFG_CNT_W-1:0] entry_count;
    logic                 search_mode;
    ctrl_cmd_t            cmd;
    dp_status_t           status;

    sks_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count),
        .search_mode (search_mode)
    );

    sks_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sks_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .entry_index (entry_index),
        .key_value   (key_value),
        .entry_count (entry_count),
        .search_mode (search_mode),
        .status      (status),
        .done        (done),
        .found       (found),
        .position    (position)
    );

endmodule

`default_nettype wire
